[rtl/core/fpct_pkg.sv]
package fpct_pkg;

    localparam int MAX_CHUNKS = 16;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
    localparam int DATA_W     = 16;

    typedef enum logic [1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_FREE     = 2'd1,
        CMD_COALESCE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        FIT_WORST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_FIRST = 2'd2
    } t_fit;

    typedef enum logic {
        CFG_HEAP_SIZE  = 1'b0,
        CFG_FIT_POLICY = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] length;
    } t_chunk;

    typedef struct packed {
        logic take_next;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic              clear;
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] req;
        logic [1:0]        policy;
    } t_scan_ctl;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  pick;
        logic [DATA_W-1:0] pick_len;
        logic [DATA_W-1:0] total;
        logic [DATA_W:0]   last_end;
    } t_scan_res;

endpackage

[rtl/core/fpct_cell.sv]
module fpct_cell (
    input  logic               i_clk,
    input  fpct_pkg::t_cell_ctl i_ctl,
    input  fpct_pkg::t_chunk    i_next,
    input  fpct_pkg::t_chunk    i_load,
    output fpct_pkg::t_chunk    o_chunk
);

    fpct_pkg::t_chunk r_chunk;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_chunk <= i_load;
        end else if (i_ctl.take_next) begin
            r_chunk <= i_next;
        end
    end

    assign o_chunk = r_chunk;

endmodule

[rtl/core/fpct_scan.sv]
module fpct_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fpct_pkg::t_scan_ctl i_ctl,
    input  fpct_pkg::t_chunk    i_head,
    output fpct_pkg::t_scan_res o_res
);

    fpct_pkg::t_scan_res r_res;

    logic                            w_valid;
    logic                            w_fits;
    logic                            w_take;
    logic                            w_last;
    logic [fpct_pkg::DATA_W:0]       w_sum;
    logic [fpct_pkg::DATA_W-1:0]     w_total;
    logic [fpct_pkg::DATA_W:0]       w_end;

    always_comb begin
        w_valid = fpct_pkg::CNT_W'(i_ctl.idx) < i_ctl.count;
        w_fits  = w_valid && (i_head.length >= i_ctl.req);
        case (i_ctl.policy)
            fpct_pkg::FIT_WORST: w_take = !r_res.found || (i_head.length >= r_res.pick_len);
            fpct_pkg::FIT_BEST:  w_take = !r_res.found || (i_head.length < r_res.pick_len);
            default:             w_take = !r_res.found;
        endcase
        // running total saturates, which equals saturating the full sum
        w_sum   = {1'b0, r_res.total} + {1'b0, i_head.length};
        w_total = w_sum[fpct_pkg::DATA_W] ? {fpct_pkg::DATA_W{1'b1}}
                                          : w_sum[fpct_pkg::DATA_W-1:0];
        w_last  = w_valid && (fpct_pkg::CNT_W'(i_ctl.idx) ==
                              (i_ctl.count - fpct_pkg::CNT_W'(1)));
        w_end   = {1'b0, i_head.start} + {1'b0, i_head.length};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_res.found    <= 1'b0;
            r_res.total    <= '0;
            r_res.pick     <= '0;
            r_res.pick_len <= '0;
            r_res.last_end <= '0;
        end else if (i_ctl.en) begin
            if (w_fits && w_take) begin
                r_res.found    <= 1'b1;
                r_res.pick     <= i_ctl.idx;
                r_res.pick_len <= i_head.length;
            end
            if (w_valid) begin
                r_res.total <= w_total;
            end
            if (w_last) begin
                r_res.last_end <= w_end;
            end
        end
    end

    assign o_res = r_res;

endmodule

[rtl/core/fit_policy_chunk_table_top.sv]
// every command rotates the chunk ring once in the scan state, then updates the table in the done state
// busy covers the scan and the update; the result strobe comes as busy falls
// a new command is taken only when idle, after the full rotation of the cell ring
// results are shown for one cycle only; the receiver cannot stall
// synchronous active-low reset: empty table, heap size 1024, worst fit
module fit_policy_chunk_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_request_size,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_ok,
    output logic [15:0] o_freed_size,
    output logic [4:0]  o_scanned_count
);

    localparam int MAX = fpct_pkg::MAX_CHUNKS;
    localparam int IW  = fpct_pkg::IDX_W;
    localparam int CW  = fpct_pkg::CNT_W;
    localparam int DW  = fpct_pkg::DATA_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} t_state;

    t_state                r_state;
    fpct_pkg::t_cmd        r_cmd;
    logic [DW-1:0]         r_req;
    logic [IW-1:0]         r_idx;
    logic [CW-1:0]         r_count;
    logic [DW-1:0]         r_heap;
    logic [1:0]            r_policy;
    logic                  r_valid;
    logic                  r_ok;
    logic [DW-1:0]         r_freed;
    logic [CW-1:0]         r_scanned;

    logic                  n_ok;
    logic [DW-1:0]         n_freed;
    logic [CW-1:0]         n_scanned;
    logic [CW-1:0]         n_count;

    fpct_pkg::t_chunk      w_chunk [MAX];
    fpct_pkg::t_cell_ctl   w_ctl   [MAX];
    fpct_pkg::t_chunk      w_load;
    fpct_pkg::t_scan_ctl   w_scan_ctl;
    fpct_pkg::t_scan_res   w_res;
    logic                  w_alloc_ok;
    logic                  w_first_fit;
    logic [IW-1:0]         w_windex;
    logic [DW+1:0]         w_new_end;

    genvar k;
    generate
        for (k = 0; k < MAX; k++) begin : g_cell
            localparam int NEXT = (k + 1) % MAX;
            fpct_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[k]),
                .i_next  (w_chunk[NEXT]),
                .i_load  (w_load),
                .o_chunk (w_chunk[k])
            );
        end
    endgenerate

    always_comb begin
        w_scan_ctl.clear  = (r_state == ST_IDLE) && start;
        w_scan_ctl.en     = (r_state == ST_SCAN);
        w_scan_ctl.idx    = r_idx;
        w_scan_ctl.count  = r_count;
        w_scan_ctl.req    = r_req;
        w_scan_ctl.policy = r_policy;
    end

    fpct_scan u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_scan_ctl),
        .i_head (w_chunk[0]),
        .o_res  (w_res)
    );

    always_comb begin
        w_new_end   = {1'b0, w_res.last_end} + {2'b00, r_req};
        w_alloc_ok  = (r_req <= r_heap) &&
                      ((r_count == '0) ||
                       ((r_count < CW'(MAX)) && (w_new_end < {2'b00, r_heap})));
        w_first_fit = (r_policy != fpct_pkg::FIT_WORST) && (r_policy != fpct_pkg::FIT_BEST);
        w_windex    = (r_count == '0) ? '0 : r_count[IW-1:0];

        w_load      = '0;
        n_ok        = 1'b0;
        n_freed     = '0;
        n_scanned   = '0;
        n_count     = r_count;
        for (int j = 0; j < MAX; j++) begin
            w_ctl[j] = '0;
        end

        case (r_state)
            ST_SCAN: begin
                for (int j = 0; j < MAX; j++) begin
                    w_ctl[j].take_next = 1'b1;
                end
            end
            ST_DONE: begin
                case (r_cmd)
                    fpct_pkg::CMD_ALLOC: begin
                        if (w_alloc_ok) begin
                            w_load.start  = (r_count == '0) ? '0 : w_res.last_end[DW-1:0];
                            w_load.length = r_req;
                            for (int j = 0; j < MAX; j++) begin
                                w_ctl[j].load = (IW'(j) == w_windex);
                            end
                            n_ok    = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    fpct_pkg::CMD_FREE: begin
                        n_scanned = r_count;
                        if (w_res.found) begin
                            // close the gap: entries above the pick move down one cell
                            for (int j = 0; j < MAX; j++) begin
                                w_ctl[j].take_next = (IW'(j) >= w_res.pick);
                            end
                            n_ok    = 1'b1;
                            n_freed = w_res.pick_len;
                            n_count = r_count - CW'(1);
                            if (w_first_fit) begin
                                n_scanned = CW'(w_res.pick) + CW'(1);
                            end
                        end
                    end
                    fpct_pkg::CMD_COALESCE: begin
                        w_load.start  = '0;
                        w_load.length = w_res.total;
                        w_ctl[0].load = 1'b1;
                        n_ok          = 1'b1;
                        n_count       = CW'(1);
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_count  <= '0;
            r_heap   <= 16'd1024;
            r_policy <= fpct_pkg::FIT_WORST;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (fpct_pkg::t_cfg_idx'(i_cfg_index))
                    fpct_pkg::CFG_HEAP_SIZE:  r_heap   <= i_cfg_data;
                    fpct_pkg::CFG_FIT_POLICY: r_policy <= i_cfg_data[1:0];
                    default:                  r_heap   <= r_heap;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_cmd   <= fpct_pkg::t_cmd'(i_command);
                        r_req   <= i_request_size;
                        r_idx   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_idx <= r_idx + IW'(1);
                    if (r_idx == IW'(MAX - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_count   <= n_count;
                    r_ok      <= n_ok;
                    r_freed   <= n_freed;
                    r_scanned <= n_scanned;
                    r_valid   <= 1'b1;
                    r_state   <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state != ST_IDLE);
    // register writes only between commands
    assign o_cfg_ready     = (r_state == ST_IDLE);
    assign o_valid         = r_valid;
    assign o_ok            = r_ok;
    assign o_freed_size    = r_freed;
    assign o_scanned_count = r_scanned;

endmodule

[rtl/core/fpct_checker.sv]
module fpct_port_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_ok,
    input logic [15:0] o_freed_size,
    input logic [4:0]  o_scanned_count
);

    // a result never overlaps a command still in flight
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted command did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_fail_no_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_freed_size == 16'd0))
        else $error("failed command reports a freed size");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_scanned_count <= 5'(fpct_pkg::MAX_CHUNKS)))
        else $error("scanned count above table depth");

endmodule

bind fit_policy_chunk_table_top fpct_port_props u_fpct_checker (.*);

[sim/fpct_checker.sv]
`timescale 1ns / 1ps

module fpct_checker
    import fpct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [1:0]        i_command,
    input  logic [DATA_W-1:0] i_request_size,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  logic              i_res_valid,
    input  logic              i_ok,
    input  logic [DATA_W-1:0] i_freed_size,
    input  logic [4:0]        i_scanned_count,
    output int                o_fail_count,
    output int                o_results_due
);

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] freed;
        logic [4:0]        scanned;
    } t_answer;

    logic [DATA_W-1:0] heap_size;
    logic [1:0]        policy;
    logic [DATA_W-1:0] seg_start [MAX_CHUNKS];
    logic [DATA_W-1:0] seg_len   [MAX_CHUNKS];
    int unsigned       seg_count;
    t_answer           answer_q [$];
    int                n_fail;

    task automatic report_mismatch(input string what, input int got, input int want);
        n_fail++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // applies one command to the local copy of the chunk table
    task automatic run_table_op(input t_cmd cmd, input logic [DATA_W-1:0] req,
                                output t_answer ans);
        int unsigned end_addr;
        int unsigned total;
        int unsigned pick;
        int unsigned pick_len;
        int unsigned k;
        bit          found;
        bit          stop;
        ans      = '0;
        found    = 1'b0;
        stop     = 1'b0;
        pick     = 0;
        pick_len = 0;
        total    = 0;
        case (cmd)
            CMD_ALLOC: begin
                if (req <= heap_size) begin
                    if (seg_count == 0) begin
                        seg_start[0] = '0;
                        seg_len[0]   = req;
                        seg_count    = 1;
                        ans.ok       = 1'b1;
                    end else if (seg_count < MAX_CHUNKS) begin
                        end_addr = seg_start[seg_count-1] + seg_len[seg_count-1];
                        if (end_addr + req < heap_size) begin
                            seg_start[seg_count] = end_addr[DATA_W-1:0];
                            seg_len[seg_count]   = req;
                            seg_count++;
                            ans.ok = 1'b1;
                        end
                    end
                end
            end
            CMD_FREE: begin
                for (k = 0; k < seg_count && !stop; k++) begin
                    ans.scanned++;
                    if (seg_len[k] >= req) begin
                        if (policy == FIT_WORST) begin
                            // ties go to the later entry
                            if (!found || seg_len[k] >= pick_len) begin
                                found = 1'b1; pick = k; pick_len = seg_len[k];
                            end
                        end else if (policy == FIT_BEST) begin
                            // ties stay with the earlier entry
                            if (!found || seg_len[k] < pick_len) begin
                                found = 1'b1; pick = k; pick_len = seg_len[k];
                            end
                        end else begin
                            found = 1'b1; pick = k; pick_len = seg_len[k];
                            stop  = 1'b1;
                        end
                    end
                end
                if (found) begin
                    for (k = pick; k + 1 < seg_count; k++) begin
                        seg_start[k] = seg_start[k+1];
                        seg_len[k]   = seg_len[k+1];
                    end
                    seg_count--;
                    ans.ok    = 1'b1;
                    ans.freed = pick_len[DATA_W-1:0];
                end
            end
            CMD_COALESCE: begin
                for (k = 0; k < seg_count; k++)
                    total += seg_len[k];
                if (total > 16'hFFFF)
                    total = 16'hFFFF;
                seg_start[0] = '0;
                seg_len[0]   = total[DATA_W-1:0];
                seg_count    = 1;
                ans.ok       = 1'b1;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_answer fresh;
        t_answer due;
        if (!i_rst_n) begin
            heap_size = 16'd1024;
            policy    = FIT_WORST;
            seg_count = 0;
            answer_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_HEAP_SIZE)
                    heap_size = i_cfg_data;
                else
                    policy = i_cfg_data[1:0];
            end
            if (i_res_valid) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 1, 0);
                end else begin
                    due = answer_q.pop_front();
                    if (i_ok !== due.ok)
                        report_mismatch("ok", i_ok, due.ok);
                    if (i_freed_size !== due.freed)
                        report_mismatch("freed_size", i_freed_size, due.freed);
                    if (i_scanned_count !== due.scanned)
                        report_mismatch("scanned_count", i_scanned_count, due.scanned);
                end
            end
            if (i_start && !i_busy) begin
                run_table_op(t_cmd'(i_command), i_request_size, fresh);
                answer_q.push_back(fresh);
            end
        end
        o_results_due <= answer_q.size();
        o_fail_count  <= n_fail;
    end

endmodule

[sim/tb_fit_policy_chunk_table_top.sv]
`timescale 1ns / 1ps

module tb_fit_policy_chunk_table_top;
    import fpct_pkg::*;

    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam logic [1:0] FIT_SPARE  = 2'd3;
    localparam int         N_PHASES   = 8;
    localparam int         PHASE_LEN  = 210;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [1:0]  command     = '0;
    logic [15:0] request_size = '0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_index   = 1'b0;
    logic [15:0] cfg_data    = '0;
    logic        busy;
    logic        cfg_ready;
    logic        res_valid;
    logic        res_ok;
    logic [15:0] res_freed;
    logic [4:0]  res_scanned;
    int          fail_count;
    int          results_due;

    int          idle_pct   = 0;
    int          n_sent     = 0;
    int          n_settings = 0;

    always #2 clk = ~clk;

    fit_policy_chunk_table_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (command),
        .i_request_size  (request_size),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_valid         (res_valid),
        .o_ok            (res_ok),
        .o_freed_size    (res_freed),
        .o_scanned_count (res_scanned)
    );

    fpct_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_command       (command),
        .i_request_size  (request_size),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_res_valid     (res_valid),
        .i_ok            (res_ok),
        .i_freed_size    (res_freed),
        .i_scanned_count (res_scanned),
        .o_fail_count    (fail_count),
        .o_results_due   (results_due)
    );

    // holds start until the transfer, then maybe idles for a while
    task automatic issue(input logic [1:0] cmd, input logic [15:0] req);
        start        <= 1'b1;
        command      <= cmd;
        request_size <= req;
        do @(posedge clk); while (busy);
        n_sent++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (results_due != 0 || busy);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_regs(input logic [15:0] heap, input logic [1:0] fit);
        logic [15:0] junk;
        junk = 16'($urandom);
        drain();
        write_reg(CFG_HEAP_SIZE, heap);
        // upper data bits are don't-care for the policy register
        write_reg(CFG_FIT_POLICY, {junk[15:2], fit});
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [15:0] hs;
        logic [1:0]  fit;
        logic [15:0] pal [3];
        logic [15:0] req;
        logic [1:0]  cmd;
        int          alloc_pct;
        int          r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: heap 1024, worst fit
        issue(CMD_FREE, 16'd0);
        issue(CMD_ALLOC, 16'd1025);
        issue(CMD_ALLOC, 16'd1024);
        issue(CMD_ALLOC, 16'd0);
        issue(CMD_FREE, 16'd1024);
        issue(CMD_COALESCE, 16'd0);
        issue(CMD_SPARE, 16'hFFFF);
        issue(CMD_ALLOC, 16'd7);
        issue(CMD_ALLOC, 16'd7);
        issue(CMD_FREE, 16'd7);

        set_regs(16'd1024, FIT_BEST);
        issue(CMD_ALLOC, 16'd7);
        issue(CMD_ALLOC, 16'd3);
        issue(CMD_ALLOC, 16'd3);
        issue(CMD_FREE, 16'd3);
        issue(CMD_FREE, 16'hFFFF);

        set_regs(16'hFFFF, FIT_FIRST);
        issue(CMD_COALESCE, 16'h5A5A);
        issue(CMD_ALLOC, 16'hFFFF);
        issue(CMD_FREE, 16'd1);

        // one-unit heap: best fit must take a chunk as large as the heap
        set_regs(16'd1, FIT_BEST);
        issue(CMD_COALESCE, 16'd0);
        issue(CMD_FREE, 16'd0);
        issue(CMD_ALLOC, 16'd1);
        issue(CMD_FREE, 16'd1);
        issue(CMD_ALLOC, 16'd2);

        set_regs(16'd1, FIT_SPARE);
        issue(CMD_ALLOC, 16'd0);
        issue(CMD_ALLOC, 16'd0);
        issue(CMD_FREE, 16'd0);

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin hs = 16'd1024;  fit = FIT_WORST; idle_pct = 0;  alloc_pct = 60; end
                1: begin hs = 16'hFFFF;  fit = FIT_BEST;  idle_pct = 86; alloc_pct = 70; end
                2: begin hs = 16'd1;     fit = FIT_FIRST; idle_pct = 17; alloc_pct = 50; end
                3: begin hs = 16'd512;   fit = FIT_SPARE; idle_pct = 0;  alloc_pct = 65; end
                4: begin hs = 16'd3000;  fit = FIT_BEST;  idle_pct = 86; alloc_pct = 75; end
                5: begin hs = 16'hFFFF;  fit = FIT_WORST; idle_pct = 17; alloc_pct = 55; end
                6: begin hs = 16'd40;    fit = FIT_FIRST; idle_pct = 0;  alloc_pct = 60; end
                default: begin
                    hs = 16'($urandom_range(1, 65535));
                    fit = 2'($urandom_range(0, 3));
                    idle_pct = 86;
                    alloc_pct = 70;
                end
            endcase
            set_regs(hs, fit);
            // a few repeated sizes so that fit ties show up
            for (int k = 0; k < 3; k++)
                pal[k] = 16'($urandom_range(0, hs / 10 + 1));
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (n == PHASE_LEN / 2 && p[0])
                    drain();
                r = $urandom_range(99);
                if (r < alloc_pct) begin
                    cmd = CMD_ALLOC;
                    r = $urandom_range(99);
                    if (r < 5)
                        req = 16'($urandom);
                    else if (r < 35)
                        req = pal[$urandom_range(0, 2)];
                    else
                        req = 16'($urandom_range(0, hs / 10 + 1));
                end else if (r < 96) begin
                    cmd = CMD_FREE;
                    r = $urandom_range(99);
                    if (r < 5)
                        req = 16'($urandom);
                    else if (r < 20)
                        req = '0;
                    else if (r < 50)
                        req = pal[$urandom_range(0, 2)];
                    else
                        req = 16'($urandom_range(0, hs / 6 + 1));
                end else if (r < 99) begin
                    cmd = CMD_COALESCE;
                    req = 16'($urandom);
                end else begin
                    cmd = CMD_SPARE;
                    req = 16'($urandom);
                end
                issue(cmd, req);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d commands over %0d register settings", n_sent, n_settings);
        $display("all fit policies, heap sizes 1 to 65535, back-to-back and idle issue");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
